/* rtl/bpe_pkg.sv */
package bpe_pkg;

  localparam int DEF_PIXELS_PER_GROUP = 16;
  localparam int DEF_MAX_PLANES = 4;
  localparam int DEF_BASE_LINE_WIDTH = 320;

  // Fixed by the width of the plane fields and of the palette index.
  localparam int WORD_BITS = 16;
  localparam int PLANE_FIELDS = 4;
  localparam int PALETTE_DEPTH = 16;
  localparam int COLOR_BITS = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_GROUP = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  palette_index;
    logic [11:0] color_word;
    logic [15:0] plane0_word;
    logic [15:0] plane1_word;
    logic [15:0] plane2_word;
    logic [15:0] plane3_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_group;
    logic       end_of_line;
  } out_pixel_t;

  // One classified item waiting between the front and the back.
  typedef struct packed {
    logic                                    is_group;
    logic [3:0]                              palette_index;
    logic [COLOR_BITS-1:0]                   color_word;
    logic [PLANE_FIELDS-1:0][WORD_BITS-1:0]  planes;
    logic                                    line_end;
  } bpe_entry_t;

endpackage

/* rtl/bitplane_to_rgb_palette_expander_top.sv */
// Channel   Direction  Handshake            Beat
// item      in         push / full          palette write or one bitplane group
// pixel     out        pop / empty          one RGB pixel with group and line flags
// cfg       in         cfg_wr               two_plane_mode register
//
// A group gives 16 pixels, one per cycle out of the back stage unless a stalled pop
// holds the output; a palette write only loads the palette and yields no beat.
// The front accepts items into a two-entry queue while the back is still emitting.
// Synchronous reset clears the palette, the line's group count, the mode and the queue.
// A stalled pop holds the output pixel and, once the queue fills, raises full.
module bitplane_to_rgb_palette_expander_top import bpe_pkg::*; #(
  parameter int PIXELS_PER_GROUP = DEF_PIXELS_PER_GROUP,
  parameter int MAX_PLANES = DEF_MAX_PLANES,
  parameter int BASE_LINE_WIDTH = DEF_BASE_LINE_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr,
  input  logic       cfg_data,
  input  logic       push,
  input  in_item_t   item,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output out_pixel_t pixel
);

  logic       q_full;
  logic       q_push;
  bpe_entry_t q_in;
  logic       q_valid;
  logic       q_take;
  bpe_entry_t q_out;

  bpe_front #(
    .PIXELS_PER_GROUP(PIXELS_PER_GROUP),
    .MAX_PLANES(MAX_PLANES),
    .BASE_LINE_WIDTH(BASE_LINE_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_wr(cfg_wr),
    .cfg_data(cfg_data),
    .push(push),
    .item(item),
    .full(full),
    .q_full(q_full),
    .q_push(q_push),
    .q_entry(q_in)
  );

  bpe_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr(q_push),
    .wr_entry(q_in),
    .q_full(q_full),
    .rd(q_take),
    .q_valid(q_valid),
    .rd_entry(q_out)
  );

  bpe_back #(
    .PIXELS_PER_GROUP(PIXELS_PER_GROUP)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_entry(q_out),
    .q_take(q_take),
    .empty(empty),
    .pop(pop),
    .pixel(pixel)
  );

endmodule

/* rtl/bpe_front.sv */
module bpe_front import bpe_pkg::*; #(
  parameter int PIXELS_PER_GROUP = DEF_PIXELS_PER_GROUP,
  parameter int MAX_PLANES = DEF_MAX_PLANES,
  parameter int BASE_LINE_WIDTH = DEF_BASE_LINE_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr,
  input  logic       cfg_data,
  input  logic       push,
  input  in_item_t   item,
  output logic       full,
  input  logic       q_full,
  output logic       q_push,
  output bpe_entry_t q_entry
);

  localparam int NPIX = (PIXELS_PER_GROUP > WORD_BITS) ? WORD_BITS : PIXELS_PER_GROUP;
  localparam int GPL0_RAW = (BASE_LINE_WIDTH + NPIX - 1) / NPIX;
  localparam int GPL1_RAW = (2 * BASE_LINE_WIDTH + NPIX - 1) / NPIX;
  localparam int GPL0 = (GPL0_RAW == 0) ? 1 : GPL0_RAW;
  localparam int GPL1 = (GPL1_RAW == 0) ? 1 : GPL1_RAW;
  localparam int GPL_MAX = (GPL0 > GPL1) ? GPL0 : GPL1;
  localparam int CW = $clog2(GPL_MAX + 1);
  localparam int PL0 = (MAX_PLANES > PLANE_FIELDS) ? PLANE_FIELDS : MAX_PLANES;
  localparam int PL1 = ((MAX_PLANES >> 1) > PLANE_FIELDS) ? PLANE_FIELDS : (MAX_PLANES >> 1);

  logic          two_plane_mode;
  logic [CW-1:0] group_count;
  logic [CW-1:0] group_count_next;
  logic [CW:0]   groups_per_line;
  logic          line_end;
  logic          accept;
  logic          is_group;
  logic [PLANE_FIELDS-1:0][WORD_BITS-1:0] raw_planes;

  assign full = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;
  assign is_group = (item.opcode == OP_GROUP);

  assign groups_per_line = two_plane_mode ? (CW+1)'(GPL1) : (CW+1)'(GPL0);
  assign line_end = ({1'b0, group_count} + (CW+1)'(1)) >= groups_per_line;
  assign group_count_next = line_end ? '0 : group_count + CW'(1);

  assign raw_planes = {item.plane3_word, item.plane2_word, item.plane1_word, item.plane0_word};

  // Planes beyond the active count are zeroed here so the back never needs the mode.
  always_comb begin
    q_entry.is_group = is_group;
    q_entry.palette_index = item.palette_index;
    q_entry.color_word = item.color_word;
    q_entry.line_end = line_end;
    for (int p = 0; p < PLANE_FIELDS; p++) begin
      if (p < (two_plane_mode ? PL1 : PL0)) begin
        q_entry.planes[p] = raw_planes[p];
      end else begin
        q_entry.planes[p] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      two_plane_mode <= 1'b0;
      group_count <= '0;
    end else begin
      if (cfg_wr) begin
        two_plane_mode <= cfg_data;
      end
      if (accept && is_group) begin
        group_count <= group_count_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && is_group && line_end |=> group_count == '0)
    else $error("group counter did not return to zero after the last group of a line");
`endif

endmodule

/* rtl/bpe_queue.sv */
module bpe_queue import bpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  bpe_entry_t wr_entry,
  output logic       q_full,
  input  logic       rd,
  output logic       q_valid,
  output bpe_entry_t rd_entry
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  bpe_entry_t    slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign q_full = (count == NW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];
  assign do_wr = wr && !q_full;
  assign do_rd = rd && q_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + NW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - NW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(QUEUE_DEPTH))
    else $error("queue holds more entries than it has slots");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + NW'(1))
    else $error("queue count missed a write");
`endif

endmodule

/* rtl/bpe_back.sv */
module bpe_back import bpe_pkg::*; #(
  parameter int PIXELS_PER_GROUP = DEF_PIXELS_PER_GROUP
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  bpe_entry_t q_entry,
  output logic       q_take,
  output logic       empty,
  input  logic       pop,
  output out_pixel_t pixel
);

  localparam int NPIX = (PIXELS_PER_GROUP > WORD_BITS) ? WORD_BITS : PIXELS_PER_GROUP;
  localparam int KW = (NPIX > 1) ? $clog2(NPIX) : 1;

  logic                                   busy;
  logic [KW-1:0]                          k;
  logic [PLANE_FIELDS-1:0][WORD_BITS-1:0] words;
  logic                                   line_end;
  logic [COLOR_BITS-1:0]                  palette [PALETTE_DEPTH];
  logic                                   out_valid;
  logic                                   advance;
  logic                                   last;
  logic [PLANE_FIELDS-1:0]                idx;
  logic [COLOR_BITS-1:0]                  color;

  assign empty = !out_valid;
  assign advance = busy && (!out_valid || pop);
  assign last = (k == KW'(NPIX - 1));
  // The next item is taken while the last pixel of the current group moves out,
  // so groups follow each other without a gap.
  assign q_take = q_valid && (!busy || (advance && last));

  always_comb begin
    for (int p = 0; p < PLANE_FIELDS; p++) begin
      idx[p] = words[p][WORD_BITS-1];
    end
  end

  assign color = palette[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        palette[i] <= '0;
      end
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_take) begin
        busy <= q_entry.is_group;
        if (!q_entry.is_group) begin
          palette[q_entry.palette_index] <= q_entry.color_word;
        end
      end else if (advance && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel.red <= {color[11:8], color[11:8]};
      pixel.green <= {color[7:4], color[7:4]};
      pixel.blue <= {color[3:0], color[3:0]};
      pixel.last_of_group <= last;
      pixel.end_of_line <= last && line_end;
    end
    if (q_take && q_entry.is_group) begin
      words <= q_entry.planes;
      k <= '0;
      line_end <= q_entry.line_end;
    end else if (advance) begin
      for (int p = 0; p < PLANE_FIELDS; p++) begin
        words[p] <= words[p] << 1;
      end
      k <= k + KW'(1);
    end
  end

`ifndef SYNTHESIS
  a_pixel_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> k <= KW'(NPIX - 1))
    else $error("pixel counter ran past the end of the group");
  a_eol_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel.end_of_line |-> pixel.last_of_group)
    else $error("end of line flagged on a pixel that does not close its group");
`endif

endmodule
